// File: rtl/incdf_pkg.sv
`timescale 1ns / 1ps
package incdf_pkg;

  // horner accumulators and the divider use this width throughout
  localparam int AccW = 40;

  localparam longint KOne  = 64'sd67108864;
  localparam longint KDen  = 64'sd10000000;
  localparam longint KHalf = 64'sd5000000;

  localparam logic signed [AccW-1:0] ONE_Q26 = 40'(KOne);

  // central region, odd numerator coefficients
  localparam logic signed [AccW-1:0] A0 = 40'((64'sd25066282 * KOne + KHalf) / KDen);
  localparam logic signed [AccW-1:0] A1 = 40'(-((64'sd186150006 * KOne + KHalf) / KDen));
  localparam logic signed [AccW-1:0] A2 = 40'((64'sd413911977 * KOne + KHalf) / KDen);
  localparam logic signed [AccW-1:0] A3 = 40'(-((64'sd254410605 * KOne + KHalf) / KDen));
  // central region, denominator coefficients
  localparam logic signed [AccW-1:0] B0 = 40'(-((64'sd84735109 * KOne + KHalf) / KDen));
  localparam logic signed [AccW-1:0] B1 = 40'((64'sd230833674 * KOne + KHalf) / KDen);
  localparam logic signed [AccW-1:0] B2 = 40'(-((64'sd210622410 * KOne + KHalf) / KDen));
  localparam logic signed [AccW-1:0] B3 = 40'((64'sd31308291 * KOne + KHalf) / KDen);
  // tails, numerator
  localparam logic signed [AccW-1:0] C0 = 40'(-((64'sd27871893 * KOne + KHalf) / KDen));
  localparam logic signed [AccW-1:0] C1 = 40'(-((64'sd22979648 * KOne + KHalf) / KDen));
  localparam logic signed [AccW-1:0] C2 = 40'((64'sd48501413 * KOne + KHalf) / KDen);
  localparam logic signed [AccW-1:0] C3 = 40'((64'sd23212128 * KOne + KHalf) / KDen);
  // tails, denominator
  localparam logic signed [AccW-1:0] D0 = 40'((64'sd35438892 * KOne + KHalf) / KDen);
  localparam logic signed [AccW-1:0] D1 = 40'((64'sd16370678 * KOne + KHalf) / KDen);

  localparam logic signed [33:0] PROB_ONE     = 34'sd4294967296;
  localparam logic signed [33:0] PROB_HALF    = 34'sd2147483648;
  localparam logic [31:0]        CENTRAL_LIM  = 32'd1803886264;
  localparam logic [29:0]        LN2_Q30      = 30'd744261118;
  localparam logic signed [31:0] Z_LOW        = -32'sd201326592;
  localparam logic signed [31:0] Z_HIGH       = 32'sd201326592;
  localparam logic signed [31:0] Z_BOUND      = 32'sd469762048;

  typedef struct packed {
    logic flag;
    logic is0;
    logic is1;
    logic central;
    logic qneg;
  } ctl_t;

  typedef struct packed {
    ctl_t                    ctl;
    logic signed [AccW-1:0]  num;
    logic signed [AccW-1:0]  den;
  } side_t;

endpackage

// File: rtl/inverse_normal_cdf_approx.sv
`timescale 1ns / 1ps
// inverse normal cdf, rational approximation in two regions
// input channel: in_valid / in_stall with probability (signed, 32 fraction bits);
//   a word is taken at a clock edge with in_valid high and in_stall low
// output channel: out_valid / out_stall with quantile (signed, 26 fraction bits)
//   and out_of_range; a word leaves at an edge with out_valid high and out_stall low
// throughput: one word per cycle while out_stall does not hold the pipe, with no gaps between words
// the path from acceptance to out_valid runs through the chain of
//   28 log squaring stages, 29 square root digit stages and 31 divider stages,
//   plus the horner and formatting stages around them
// the whole pipe advances as one: when a result sits in the output register
//   and out_stall is high, every stage holds and in_stall is raised, so no
//   word is dropped or repeated; bubbles travel as cleared valid bits
// reset (rst, synchronous, active high) clears every valid bit, the pipe
//   comes up empty and ready, payload registers keep whatever they held
// probability below 0 or above 1 gives quantile 0 with out_of_range set;
//   exactly 0 gives -3.0 and exactly 1 gives +3.0
module inverse_normal_cdf_approx (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [33:0] probability,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] quantile,
  output logic               out_of_range
);
  import incdf_pkg::*;

  localparam int Depth = 100;

  // one horner step with a q2 multiplier in q.30
  function automatic logic signed [AccW-1:0] hstep30(input logic signed [AccW-1:0] acc,
                                                     input logic signed [30:0] m,
                                                     input logic signed [AccW-1:0] c);
    logic signed [70:0] pr;
    logic signed [70:0] sh;
    pr = acc * m;
    sh = (pr + (71'sd1 <<< 29)) >>> 30;
    return sh[AccW-1:0] + c;
  endfunction

  // one horner step with an s multiplier in q.26
  function automatic logic signed [AccW-1:0] hstep26(input logic signed [AccW-1:0] acc,
                                                     input logic signed [29:0] m,
                                                     input logic signed [AccW-1:0] c);
    logic signed [69:0] pr;
    logic signed [69:0] sh;
    pr = acc * m;
    sh = (pr + (70'sd1 <<< 25)) >>> 26;
    return sh[AccW-1:0] + c;
  endfunction

  logic             en;
  logic [Depth-1:0] vld;

  // whole pipe moves unless the output word is held
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[Depth-2:0], in_valid};
      out_valid <= vld[Depth-1];
    end
  end

  // stage 0: input register
  logic signed [33:0] p0;
  always_ff @(posedge clk) begin
    if (en) p0 <= probability;
  end

  // stage 1: classify, form q and the tail argument r
  logic signed [34:0] q_full;
  logic [32:0]        absq;
  logic [33:0]        r_full;
  ctl_t               ctl_c;
  ctl_t               ctl1;
  logic signed [31:0] q1;
  logic [31:0]        r1;

  always_comb begin
    q_full        = 35'(p0) - 35'(PROB_HALF);
    absq          = q_full[34] ? 33'(-q_full) : q_full[32:0];
    r_full        = q_full[34] ? p0[33:0] : 34'(PROB_ONE - p0);
    ctl_c.flag    = (p0 < 34'sd0) || (p0 > PROB_ONE);
    ctl_c.is0     = (p0 == 34'sd0);
    ctl_c.is1     = (p0 == PROB_ONE);
    ctl_c.central = (absq <= {1'b0, CENTRAL_LIM});
    ctl_c.qneg    = q_full[34];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl1 <= ctl_c;
      q1   <= q_full[31:0];
      r1   <= r_full[31:0];
    end
  end

  // stage 2: q squared for the central path, leading one of r for the tails
  logic signed [63:0] qsq;
  logic [4:0]         k_c;
  ctl_t               ctl2;
  logic signed [31:0] q2c;
  logic signed [30:0] qq2;
  logic [31:0]        r2;
  logic [4:0]         k2;

  always_comb begin
    qsq = q1 * q1;
    k_c = '0;
    for (int i = 0; i < 32; i++) begin
      if (r1[i]) k_c = 5'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl2 <= ctl1;
      q2c  <= q1;
      qq2  <= 31'((qsq + (64'sd1 <<< 33)) >>> 34);
      r2   <= r1;
      k2   <= k_c;
    end
  end

  // stage 3: mantissa normalized to [1,2) in q.30, first horner steps
  logic [31:0]           xsh;
  logic [30:0]           x_c;
  ctl_t                  ctl3, ctl4, ctl5;
  logic signed [31:0]    q3, q4, q5;
  logic signed [30:0]    qq3, qq4, qq5;
  logic [30:0]           x3, x4, x5;
  logic [4:0]            k3, k4, k5;
  logic signed [AccW-1:0] an3, an4, an5, bd3, bd4, bd5;

  always_comb begin
    xsh = r2 << (5'd30 - k2);
    x_c = (k2 == 5'd31) ? r2[31:1] : xsh[30:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl3 <= ctl2;
      q3   <= q2c;
      qq3  <= qq2;
      x3   <= x_c;
      k3   <= k2;
      an3  <= hstep30(A3, qq2, A2);
      bd3  <= hstep30(B3, qq2, B2);
    end
  end

  // stages 4 and 5: remaining central horner steps
  always_ff @(posedge clk) begin
    if (en) begin
      ctl4 <= ctl3;
      q4   <= q3;
      qq4  <= qq3;
      x4   <= x3;
      k4   <= k3;
      an4  <= hstep30(an3, qq3, A1);
      bd4  <= hstep30(bd3, qq3, B1);
      ctl5 <= ctl4;
      q5   <= q4;
      qq5  <= qq4;
      x5   <= x4;
      k5   <= k4;
      an5  <= hstep30(an4, qq4, A0);
      bd5  <= hstep30(bd4, qq4, B0);
    end
  end

  // stage 6: central numerator q*A and last denominator step
  logic signed [71:0] qa;
  logic signed [71:0] qa_sh;
  assign qa    = q5 * an5;
  assign qa_sh = (qa + (72'sd1 <<< 31)) >>> 32;

  logic [30:0] lx [0:28];
  logic [27:0] lf [0:28];
  logic [4:0]  lk [0:28];
  side_t       lsd [0:28];

  always_ff @(posedge clk) begin
    if (en) begin
      lx[0]          <= x5;
      lf[0]          <= '0;
      lk[0]          <= k5;
      lsd[0].ctl     <= ctl5;
      lsd[0].num     <= qa_sh[AccW-1:0];
      lsd[0].den     <= hstep30(bd5, qq5, ONE_Q26);
    end
  end

  // log2 fraction, one bit per stage by square and compare
  for (genvar j = 0; j < 28; j++) begin : g_log
    logic [61:0] sq;
    logic [31:0] t;
    assign sq = lx[j] * lx[j];
    assign t  = sq[61:30];
    always_ff @(posedge clk) begin
      if (en) begin
        lx[j+1]  <= t[31] ? t[31:1] : t[30:0];
        lf[j+1]  <= {lf[j][26:0], t[31]};
        lk[j+1]  <= lk[j];
        lsd[j+1] <= lsd[j];
      end
    end
  end

  // -ln r in q.28, then load the square root digit pipe with it shifted to q.52
  logic [33:0] nl2;
  logic [63:0] nlp;
  logic [33:0] nln;
  assign nl2 = {6'd32 - {1'b0, lk[28]}, 28'd0} - {6'd0, lf[28]};
  assign nlp = nl2 * LN2_Q30;
  assign nln = 34'((nlp + (64'd1 << 29)) >> 30);

  logic [57:0] svs  [0:29];
  logic [31:0] srem [0:29];
  logic [28:0] sroot [0:29];
  side_t       ssd  [0:29];

  always_ff @(posedge clk) begin
    if (en) begin
      svs[0]   <= {nln, 24'd0};
      srem[0]  <= '0;
      sroot[0] <= '0;
      ssd[0]   <= lsd[28];
    end
  end

  // floor square root, one result bit per stage
  for (genvar j = 0; j < 29; j++) begin : g_sqrt
    logic [33:0] t;
    logic [33:0] trial;
    logic        ge;
    assign t     = {srem[j], svs[j][57:56]};
    assign trial = {3'd0, sroot[j], 2'b01};
    assign ge    = (t >= trial);
    always_ff @(posedge clk) begin
      if (en) begin
        svs[j+1]   <= {svs[j][55:0], 2'b00};
        srem[j+1]  <= ge ? 32'(t - trial) : t[31:0];
        sroot[j+1] <= {sroot[j][27:0], ge};
        ssd[j+1]   <= ssd[j];
      end
    end
  end

  // tail horner steps in s
  logic signed [29:0]     s_t;
  logic signed [29:0]     s1, s2;
  side_t                  hsd1, hsd2, hsd3;
  logic signed [AccW-1:0] cn1, cn2, cn3, dd1, dd2, dd3;
  assign s_t = {1'b0, sroot[29]};

  always_ff @(posedge clk) begin
    if (en) begin
      s1   <= s_t;
      hsd1 <= ssd[29];
      cn1  <= hstep26(C3, s_t, C2);
      dd1  <= hstep26(D1, s_t, D0);
      s2   <= s1;
      hsd2 <= hsd1;
      cn2  <= hstep26(cn1, s1, C1);
      dd2  <= hstep26(dd1, s1, ONE_Q26);
      hsd3 <= hsd2;
      cn3  <= hstep26(cn2, s2, C0);
      dd3  <= dd2;
    end
  end

  // pick the region, fix the sign and load the divider
  logic signed [AccW-1:0] sel_num;
  logic signed [AccW-1:0] sel_den;
  logic signed [AccW-1:0] fix_den;
  logic [AccW-1:0]        sel_mag;
  logic [66:0]            dividend;

  always_comb begin
    sel_num  = hsd3.ctl.central ? hsd3.num : cn3;
    sel_den  = hsd3.ctl.central ? hsd3.den : dd3;
    fix_den  = (sel_den < 40'sd1) ? 40'sd1 : sel_den;
    sel_mag  = sel_num[AccW-1] ? 40'(-sel_num) : sel_num;
    dividend = {1'b0, sel_mag, 26'd0} + 67'(fix_den[AccW-1:1]);
  end

  logic [AccW-1:0] drem [0:31];
  logic [30:0]     dlow [0:31];
  logic [30:0]     dquo [0:31];
  logic [AccW-1:0] dden [0:31];
  logic            dneg [0:31];
  ctl_t            dctl [0:31];

  always_ff @(posedge clk) begin
    if (en) begin
      drem[0] <= 40'(dividend[66:31]);
      dlow[0] <= dividend[30:0];
      dquo[0] <= '0;
      dden[0] <= fix_den;
      dneg[0] <= sel_num[AccW-1] ^ (!hsd3.ctl.central && hsd3.ctl.qneg);
      dctl[0] <= hsd3.ctl;
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar j = 0; j < 31; j++) begin : g_div
    logic [AccW:0] t;
    logic          ge;
    assign t  = {drem[j], dlow[j][30]};
    assign ge = (t >= {1'b0, dden[j]});
    always_ff @(posedge clk) begin
      if (en) begin
        drem[j+1] <= ge ? 40'(t - {1'b0, dden[j]}) : t[AccW-1:0];
        dlow[j+1] <= {dlow[j][29:0], 1'b0};
        dquo[j+1] <= {dquo[j][29:0], ge};
        dden[j+1] <= dden[j];
        dneg[j+1] <= dneg[j];
        dctl[j+1] <= dctl[j];
      end
    end
  end

  // output register with the special cases
  logic signed [31:0] zmag;
  logic signed [31:0] z;
  always_comb begin
    zmag = {1'b0, dquo[31]};
    if (dctl[31].flag)     z = '0;
    else if (dctl[31].is0) z = Z_LOW;
    else if (dctl[31].is1) z = Z_HIGH;
    else                   z = dneg[31] ? -zmag : zmag;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quantile     <= z;
      out_of_range <= dctl[31].flag;
    end
  end

  // out of range words carry a zero quantile
  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_range |-> quantile == 32'sd0)
    else $error("out of range word with nonzero quantile");

  // the approximation never leaves seven in magnitude
  a_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (quantile < Z_BOUND) && (quantile > -Z_BOUND))
    else $error("quantile beyond expected range");

  // the rational denominator stays positive for every in-range word strictly between 0 and 1
  a_den_pos: assert property (@(posedge clk) disable iff (rst)
    vld[67] && !hsd3.ctl.flag && !hsd3.ctl.is0 && !hsd3.ctl.is1 |-> sel_den > 40'sd0)
    else $error("nonpositive denominator");

endmodule
